// ===== rtl/grc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_pkg
// shared types and constants of the grid ray wall caster
// ----------------------------------------------------------------------------
package grc_pkg;

	localparam int MAP_DIM_DEF = 32;
	localparam int COLUMNS_DEF = 1024;

	localparam int POS_W     = 14;
	localparam int CELL_SH   = 9;
	localparam int DIR_W     = 16;
	localparam int DIST_W    = 24;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam int DIV_NUM_W = 24;
	localparam int DIV_DEN_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PLAYER_X   = 3'd0,
		CFG_PLAYER_Y   = 3'd1,
		CFG_HORIZON    = 3'd2,
		CFG_MAP_WIDTH  = 3'd3,
		CFG_MAP_HEIGHT = 3'd4,
		CFG_PROJ_SCALE = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		OP_WRITE_CELL = 1'b0,
		OP_CAST       = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV_ISSUE,
		ST_DIV_WAIT,
		ST_WALK,
		ST_LOOK,
		ST_MUL_CORR,
		ST_DIVH_ISSUE,
		ST_DIVH_WAIT,
		ST_MUL_TEX,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== rtl/grc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_if
// request and result channels of the grid ray wall caster
// ----------------------------------------------------------------------------
interface grc_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [4:0]  cell_x;
	logic [4:0]  cell_y;
	logic        cell_is_wall;
	logic signed [15:0] ray_dir_x;
	logic signed [15:0] ray_dir_y;
	logic [15:0] angle_cos;
	logic [9:0]  column;

	modport source (output valid, opcode, cell_x, cell_y, cell_is_wall, ray_dir_x,
		ray_dir_y, angle_cos, column, input ready);
	modport sink (input valid, opcode, cell_x, cell_y, cell_is_wall, ray_dir_x,
		ray_dir_y, angle_cos, column, output ready);
endinterface

interface grc_rsp_if;
	logic        valid;
	logic        ready;
	logic [9:0]  out_column;
	logic        hit;
	logic        side;
	logic [15:0] corrected_distance;
	logic [7:0]  brightness;
	logic [15:0] wall_height;
	logic signed [15:0] wall_top;
	logic [7:0]  tex_u;

	modport source (output valid, out_column, hit, side, corrected_distance, brightness,
		wall_height, wall_top, tex_u, input ready);
	modport sink (input valid, out_column, hit, side, corrected_distance, brightness,
		wall_height, wall_top, tex_u, output ready);
endinterface

// ===== rtl/grid_ray_wall_caster.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_wall_caster
// dda ray caster over a one-bit wall map, one shared divider and multiplier
// ----------------------------------------------------------------------------
// sequence: a cell write goes to the map as it is accepted; a cast runs four
//   divisions, one map read per grid step (steps <= 4*MAP_DIM+8), then on a hit
//   the distance correction, the height division and the texture product
// throughput: one item at a time, set by the serial divider and the map port
// reset: map clear pass over all MAP_DIM*MAP_DIM cells, not ready meanwhile
// ----------------------------------------------------------------------------
module grid_ray_wall_caster import grc_pkg::*; #(
	parameter int MAP_DIM = MAP_DIM_DEF,
	parameter int COLUMNS = COLUMNS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	grc_req_if.sink              req,
	grc_rsp_if.source            rsp
);

	localparam int DEPTH  = MAP_DIM * MAP_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	// map coordinates run one cell past either edge, and start anywhere in 0..31
	localparam int CW     = (($clog2(MAP_DIM) > 5) ? $clog2(MAP_DIM) : 5) + 2;
	localparam int GUARD  = 4 * MAP_DIM + 8;
	localparam int GC_W   = $clog2(GUARD + 1);

	// configuration registers
	logic [13:0] player_x_q, player_y_q;
	logic [9:0]  horizon_q;
	logic [5:0]  map_w_q, map_h_q;
	logic [15:0] proj_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= '0;
			player_y_q <= '0;
			horizon_q  <= 10'd240;
			map_w_q    <= 6'd32;
			map_h_q    <= 6'd32;
			proj_q     <= 16'd9000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PLAYER_X:   player_x_q <= cfg_wdata[13:0];
				CFG_PLAYER_Y:   player_y_q <= cfg_wdata[13:0];
				CFG_HORIZON:    horizon_q  <= cfg_wdata[9:0];
				CFG_MAP_WIDTH:  map_w_q    <= cfg_wdata[5:0];
				CFG_MAP_HEIGHT: map_h_q    <= cfg_wdata[5:0];
				CFG_PROJ_SCALE: proj_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	state_t state_q, state_d;

	logic              accept;
	logic              rsp_valid_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [1:0]        div_idx_q;
	logic [GC_W-1:0]   step_cnt_q;
	logic              oob_q;
	logic              rd_q;
	logic              hit_q;
	logic              out_free;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// latched cast item
	logic signed [15:0] dx_q, dy_q;
	logic [15:0]        cos_q;
	logic [9:0]         col_q;
	logic               negx, negy;
	logic [15:0]        magx, magy;

	assign negx = dx_q[15];
	assign negy = dy_q[15];
	assign magx = negx ? 16'(-dx_q) : dx_q;
	assign magy = negy ? 16'(-dy_q) : dy_q;

	// walk state
	logic [DIST_W-1:0]  delx_q, dely_q, sx_q, sy_q, dist_q;
	logic signed [CW-1:0] mx_q, my_q;
	logic               side_q;

	// map memory
	logic              mem [DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_wdata;
	logic [ADDR_W-1:0] rd_addr;
	logic              cell_ok;

	assign cell_ok = (32'(req.cell_x) < MAP_DIM) && (32'(req.cell_y) < MAP_DIM);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = 1'b0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && req.opcode == OP_WRITE_CELL && cell_ok) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(32'(req.cell_y) * MAP_DIM + 32'(req.cell_x));
			mem_wdata = req.cell_is_wall;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[rd_addr];
	end

	// one grid step: cross the nearer line, a tie steps in y
	logic                 take_x;
	logic signed [CW-1:0] nx, ny;
	logic [DIST_W:0]      sx_sum, sy_sum;
	logic                 n_oob;
	int                   w_lim, h_lim;

	assign take_x = sx_q < sy_q;
	assign sx_sum = {1'b0, sx_q} + {1'b0, delx_q};
	assign sy_sum = {1'b0, sy_q} + {1'b0, dely_q};
	assign w_lim  = (32'(map_w_q) > MAP_DIM) ? MAP_DIM : 32'(map_w_q);
	assign h_lim  = (32'(map_h_q) > MAP_DIM) ? MAP_DIM : 32'(map_h_q);

	always_comb begin
		nx = mx_q;
		ny = my_q;
		if (take_x)
			nx = negx ? mx_q - CW'(1) : mx_q + CW'(1);
		else
			ny = negy ? my_q - CW'(1) : my_q + CW'(1);
		n_oob = (nx < 0) || (ny < 0) || (int'(nx) >= w_lim) || (int'(ny) >= h_lim);
		rd_addr = n_oob ? '0 : ADDR_W'(int'(ny) * MAP_DIM + int'(nx));
	end

	// divider operand selection
	logic [9:0] offx, offy;
	assign offx = negx ? {1'b0, player_x_q[CELL_SH-1:0]}
		: 10'd512 - {1'b0, player_x_q[CELL_SH-1:0]};
	assign offy = negy ? {1'b0, player_y_q[CELL_SH-1:0]}
		: 10'd512 - {1'b0, player_y_q[CELL_SH-1:0]};

	// shared multiplier, registered
	logic signed [24:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [41:0] mul_q;

	assign mul_a = $signed({1'b0, dist_q});
	assign mul_b = (state_q == ST_MUL_CORR) ? $signed({1'b0, cos_q})
		: (side_q ? 17'(dx_q) : 17'(dy_q));

	always_ff @(posedge clk)
		mul_q <= mul_a * mul_b;

	// corrected distance from the product, saturated
	logic [24:0] corr_full;
	logic [15:0] corr_sat;
	assign corr_full = mul_q[39:15];
	assign corr_sat  = (|corr_full[24:16]) ? 16'hFFFF : corr_full[15:0];

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = 24'h800000;
		div_req.den   = magx;
		case (state_q)
			ST_DIV_ISSUE: begin
				div_req.start = 1'b1;
				case (div_idx_q)
					2'd0: div_req.den = magx;
					2'd1: div_req.den = magy;
					2'd2: begin
						div_req.num = {offx, 14'b0};
						div_req.den = magx;
					end
					default: begin
						div_req.num = {offy, 14'b0};
						div_req.den = magy;
					end
				endcase
			end
			ST_DIVH_ISSUE: begin
				div_req.start = 1'b1;
				div_req.num   = {4'b0, proj_q, 4'b0};
				div_req.den   = (corr_sat == '0) ? 16'd1 : corr_sat;
			end
			default: ;
		endcase
	end

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic [DIST_W-1:0] div_val;
	logic              div_mag_zero;
	assign div_mag_zero = (div_idx_q[0] == 1'b0) ? (magx == '0) : (magy == '0);
	assign div_val      = div_mag_zero ? DIST_MAX : div_rsp.quot;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:
				if (clr_cnt_q == ADDR_W'(DEPTH - 1))
					state_d = ST_IDLE;
			ST_IDLE:
				if (accept && req.opcode == OP_CAST && 32'(req.column) < COLUMNS)
					state_d = ST_DIV_ISSUE;
			ST_DIV_ISSUE:
				state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:
				if (div_rsp.done)
					state_d = (div_idx_q == 2'd3) ? ST_WALK : ST_DIV_ISSUE;
			ST_WALK:
				state_d = ST_LOOK;
			ST_LOOK:
				if (oob_q)
					state_d = ST_FINISH;
				else if (rd_q)
					state_d = (dist_q == '0) ? ST_FINISH : ST_MUL_CORR;
				else if (step_cnt_q == GC_W'(GUARD))
					state_d = ST_FINISH;
				else
					state_d = ST_WALK;
			ST_MUL_CORR:
				state_d = ST_DIVH_ISSUE;
			ST_DIVH_ISSUE:
				state_d = ST_DIVH_WAIT;
			ST_DIVH_WAIT:
				if (div_rsp.done)
					state_d = ST_MUL_TEX;
			ST_MUL_TEX:
				state_d = ST_FINISH;
			ST_FINISH:
				if (out_free)
					state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_cnt_q  <= '0;
			div_idx_q  <= '0;
			step_cnt_q <= '0;
			hit_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == ST_IDLE) begin
				div_idx_q  <= '0;
				step_cnt_q <= '0;
				hit_q      <= 1'b0;
			end
			if (state_q == ST_DIV_WAIT && div_rsp.done)
				div_idx_q <= div_idx_q + 1'b1;
			if (state_q == ST_WALK)
				step_cnt_q <= step_cnt_q + 1'b1;
			if (state_q == ST_LOOK && !oob_q && rd_q && dist_q != '0)
				hit_q <= 1'b1;
		end
	end

	// datapath registers
	logic [15:0]       corr_q;
	logic [DIV_NUM_W-1:0] h_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q  <= req.ray_dir_x;
			dy_q  <= req.ray_dir_y;
			cos_q <= req.angle_cos;
			col_q <= req.column;
			mx_q  <= CW'(player_x_q[POS_W-1:CELL_SH]);
			my_q  <= CW'(player_y_q[POS_W-1:CELL_SH]);
			dist_q <= '0;
			side_q <= 1'b0;
		end
		if (state_q == ST_DIV_WAIT && div_rsp.done) begin
			case (div_idx_q)
				2'd0: delx_q <= div_val;
				2'd1: dely_q <= div_val;
				2'd2: sx_q   <= div_val;
				default: sy_q <= div_val;
			endcase
		end
		if (state_q == ST_WALK) begin
			mx_q  <= nx;
			my_q  <= ny;
			oob_q <= n_oob;
			if (take_x) begin
				dist_q <= sx_q;
				sx_q   <= sx_sum[DIST_W] ? DIST_MAX : sx_sum[DIST_W-1:0];
				side_q <= 1'b0;
			end else begin
				dist_q <= sy_q;
				sy_q   <= sy_sum[DIST_W] ? DIST_MAX : sy_sum[DIST_W-1:0];
				side_q <= 1'b1;
			end
		end
		if (state_q == ST_DIVH_ISSUE)
			corr_q <= corr_sat;
		if (state_q == ST_DIVH_WAIT && div_rsp.done)
			h_q <= div_rsp.quot;
	end

	// result fields
	logic [10:0]        b8;
	logic [13:0]        b7;
	logic [17:0]        b_q5;
	logic [7:0]         bright;
	logic signed [21:0] top_full;
	logic [22:0]        tex_sum;
	logic [13:0]        tex_pos;

	always_comb begin
		// shade 2040 - d clamped at 160, then /8 or *7/80
		b8      = (corr_q >= 16'd1880) ? 11'd160 : 11'(16'd2040 - corr_q);
		b7      = 14'(b8) * 14'd7;
		b_q5    = 18'(b7[13:4]) * 18'd205;
		bright  = side_q ? b_q5[17:10] : b8[10:3];
		top_full = $signed({12'b0, horizon_q}) - $signed({2'b0, h_q[20:1]});
		tex_pos = side_q ? player_x_q : player_y_q;
		tex_sum = {tex_pos[8:0], 14'b0} + mul_q[22:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (state_q == ST_FINISH && out_free)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			rsp.out_column <= col_q;
			rsp.hit        <= hit_q;
			rsp.side       <= hit_q & side_q;
			rsp.corrected_distance <= hit_q ? corr_q : '0;
			rsp.brightness <= hit_q ? bright : '0;
			rsp.wall_height <= !hit_q ? '0 : ((|h_q[23:16]) ? 16'hFFFF : h_q[15:0]);
			rsp.wall_top   <= !hit_q ? '0 : ((top_full < -22'sd32768) ? 16'sh8000
				: top_full[15:0]);
			rsp.tex_u      <= hit_q ? tex_sum[22:15] : '0;
		end
	end

	assign rsp.valid = rsp_valid_q;

`ifndef SYNTH
	a_no_ready_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !req.ready)
		else $error("ready during map clear");
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");
	a_guard_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> step_cnt_q < GC_W'(GUARD))
		else $error("walk past step guard");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.hit) |-> (rsp.corrected_distance == '0 && rsp.tex_u == '0))
		else $error("miss result carries data");
`endif

endmodule

// ===== rtl/grc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module grc_div import grc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W+1:0] diff;
	logic                 ge;

	assign rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = !diff[DIV_DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the grid ray wall caster: random wall maps and ray
// casts under changing viewer and screen settings, every result beat checked
// against an in-bench fixed point ray walker, with random source and sink gaps
// ----------------------------------------------------------------------------
module tb;
	import grc_pkg::*;

	localparam int MAP_N      = 32;
	localparam int CYCLE_CAP  = 1000000;
	localparam int WALK_LIMIT = 4 * MAP_N + 8;
	localparam int DRAIN_WAIT = 450;

	// one request beat
	typedef struct {
		opcode_t     op;
		logic [4:0]  cx;
		logic [4:0]  cy;
		logic        is_wall;
		logic [15:0] dir_x;
		logic [15:0] dir_y;
		logic [15:0] cosv;
		logic [9:0]  col;
	} ray_req_t;

	// one result beat
	typedef struct {
		logic [9:0]  col;
		logic        hit;
		logic        side;
		logic [15:0] corr_dist;
		logic [7:0]  bright;
		logic [15:0] height;
		logic [15:0] top;
		logic [7:0]  tex;
	} ray_hit_t;

	// ------------------------------------------------------------------
	// scoreboard: own copy of map and registers, fifo of expected misses and hits
	// ------------------------------------------------------------------
	class ray_scoreboard;
		bit          walls [MAP_N*MAP_N];
		int unsigned pos_x, pos_y, horizon, width_cells, height_cells, scale;
		ray_hit_t    pending_hits [$];
		int          errors;

		function new();
			foreach (walls[i]) walls[i] = 0;
			pos_x = 0; pos_y = 0; horizon = 240;
			width_cells = 32; height_cells = 32; scale = 9000;
			errors = 0;
		endfunction

		function void set_reg(int unsigned idx, int unsigned val);
			case (idx)
				CFG_PLAYER_X:   pos_x = val & 16'h3FFF;
				CFG_PLAYER_Y:   pos_y = val & 16'h3FFF;
				CFG_HORIZON:    horizon = val & 16'h03FF;
				CFG_MAP_WIDTH:  width_cells = val & 16'h003F;
				CFG_MAP_HEIGHT: height_cells = val & 16'h003F;
				CFG_PROJ_SCALE: scale = val & 16'hFFFF;
				default: ;
			endcase
		endfunction

		function longint sat24(longint v);
			return (v > longint'(DIST_MAX)) ? longint'(DIST_MAX) : v;
		endfunction

		function longint step_len(longint mag);
			return (mag == 0) ? longint'(DIST_MAX) : sat24((longint'(1) << 23) / mag);
		endfunction

		function longint first_len(longint pos, bit neg, longint mag);
			longint off;
			off = pos & 511;
			if (!neg) off = 512 - off;
			return (mag == 0) ? longint'(DIST_MAX) : sat24((off << 14) / mag);
		endfunction

		function logic [7:0] tex_coord(longint pos, longint dir, longint d);
			logic [63:0] t;
			t = pos * 16384 + dir * d;
			return t[22:15];
		endfunction

		// walk the grid for one cast and work out its result beat
		function ray_hit_t cast_ray(ray_req_t r);
			ray_hit_t res;
			longint dx, dy, magx, magy, delx, dely, sx, sy, d, corr, b8, hfull, top;
			int mx, my, w, h;
			bit negx, negy, wall, side;
			dx = longint'($signed(r.dir_x));
			dy = longint'($signed(r.dir_y));
			negx = dx < 0; negy = dy < 0;
			magx = negx ? -dx : dx;
			magy = negy ? -dy : dy;
			w = (width_cells > MAP_N) ? MAP_N : width_cells;
			h = (height_cells > MAP_N) ? MAP_N : height_cells;
			mx = pos_x / 512; my = pos_y / 512;
			delx = step_len(magx); dely = step_len(magy);
			sx = first_len(pos_x, negx, magx);
			sy = first_len(pos_y, negy, magy);
			d = 0; side = 0; wall = 0;
			for (int g = 0; g < WALK_LIMIT; g++) begin
				// a tie crosses the y line
				if (sx < sy) begin
					d = sx; sx = sat24(sx + delx); mx += negx ? -1 : 1; side = 0;
				end else begin
					d = sy; sy = sat24(sy + dely); my += negy ? -1 : 1; side = 1;
				end
				if (mx < 0 || my < 0 || mx >= w || my >= h) break;
				if (walls[my*MAP_N + mx]) begin
					wall = 1;
					break;
				end
			end
			res = '{col: r.col, default: '0};
			if (!wall || d == 0) return res;
			corr = (d * longint'(r.cosv)) >>> 15;
			if (corr > 65535) corr = 65535;
			b8 = 2040 - corr;
			if (b8 < 160) b8 = 160;
			hfull = (longint'(scale) * 16) / ((corr != 0) ? corr : 1);
			top = longint'(horizon) - (hfull >>> 1);
			if (top < -32768) top = -32768;
			res.hit       = 1;
			res.side      = side;
			res.corr_dist = corr[15:0];
			res.bright    = side ? 8'((b8 * 7) / 80) : 8'(b8 / 8);
			res.height    = (hfull > 65535) ? 16'hFFFF : hfull[15:0];
			res.top       = top[15:0];
			res.tex       = side ? tex_coord(pos_x, dx, d) : tex_coord(pos_y, dy, d);
			return res;
		endfunction

		function void note_request(ray_req_t r);
			if (r.op == OP_WRITE_CELL)
				walls[r.cy*MAP_N + r.cx] = r.is_wall;
			else
				pending_hits.push_back(cast_ray(r));
		endfunction

		function void report_mismatch(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endfunction

		function void check_result(ray_hit_t got);
			ray_hit_t want;
			if (pending_hits.size() == 0) begin
				report_mismatch("unexpected result beat, column", got.col, -1);
				return;
			end
			want = pending_hits.pop_front();
			if (got.col    !== want.col)    report_mismatch("out_column", got.col, want.col);
			if (got.hit    !== want.hit)    report_mismatch("hit", got.hit, want.hit);
			if (got.side   !== want.side)   report_mismatch("side", got.side, want.side);
			if (got.corr_dist !== want.corr_dist)
				report_mismatch("corrected_distance", got.corr_dist, want.corr_dist);
			if (got.bright !== want.bright) report_mismatch("brightness", got.bright, want.bright);
			if (got.height !== want.height) report_mismatch("wall_height", got.height, want.height);
			if (got.top    !== want.top)
				report_mismatch("wall_top", $signed(got.top), $signed(want.top));
			if (got.tex    !== want.tex)    report_mismatch("tex_u", got.tex, want.tex);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	grc_req_if req ();
	grc_rsp_if rsp ();

	grid_ray_wall_caster DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	ray_scoreboard sb = new();
	int cycles = 0;
	int sent = 0;
	// idling mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both rarely
	int gap_mode = 0;

	always #5 clk = ~clk;

	initial begin
		req.valid = 0; req.opcode = OP_WRITE_CELL; req.cell_x = '0; req.cell_y = '0;
		req.cell_is_wall = 0; req.ray_dir_x = '0; req.ray_dir_y = '0;
		req.angle_cos = '0; req.column = '0;
		rsp.ready = 0;
	end

	// cycle cap, covers the map clear pass after reset too
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// sink side: stall pattern follows the idling mode
	always @(negedge clk) begin
		case (gap_mode)
			2: rsp.ready <= ($urandom_range(99) >= 47);
			3: rsp.ready <= ($urandom_range(99) >= 6);
			default: rsp.ready <= 1'b1;
		endcase
	end

	// every accepted result beat goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result('{col: rsp.out_column, hit: rsp.hit, side: rsp.side,
				corr_dist: rsp.corrected_distance, bright: rsp.brightness,
				height: rsp.wall_height, top: rsp.wall_top, tex: rsp.tex_u});
	end

	// register write, only while the block is idle
	task automatic write_reg(int unsigned idx, int unsigned val);
		@(negedge clk);
		cfg_wr_en = 1; cfg_index = idx[CFG_IDX_W-1:0]; cfg_wdata = val[CFG_DAT_W-1:0];
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	// one request beat, with optional gaps in front of it
	task automatic send_req(ray_req_t r);
		int gap_pct;
		gap_pct = (gap_mode == 1) ? 47 : (gap_mode == 3) ? 6 : 0;
		// idle mode cycles every 40 beats so gaps land on all phases of a cast
		gap_mode = (sent / 40) % 4;
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			req.valid = 0;
		end
		@(negedge clk);
		req.valid = 1; req.opcode = r.op; req.cell_x = r.cx; req.cell_y = r.cy;
		req.cell_is_wall = r.is_wall; req.ray_dir_x = r.dir_x; req.ray_dir_y = r.dir_y;
		req.angle_cos = r.cosv; req.column = r.col;
		do @(posedge clk); while (!req.ready);
		sb.note_request(r);
		sent++;
	endtask

	task automatic put_cell(int x, int y, bit is_wall);
		ray_req_t r;
		r = '{op: OP_WRITE_CELL, cx: x[4:0], cy: y[4:0], is_wall: is_wall, default: '0};
		send_req(r);
	endtask

	task automatic cast(int dx, int dy, int cosv, int col);
		ray_req_t r;
		r = '{op: OP_CAST, cx: 5'($urandom), cy: 5'($urandom), is_wall: 1'($urandom),
			dir_x: dx[15:0], dir_y: dy[15:0], cosv: cosv[15:0], col: col[9:0]};
		send_req(r);
	endtask

	// wait for all results, then let any trailing cell write settle
	task automatic drain();
		@(negedge clk);
		req.valid = 0;
		while (sb.pending_hits.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_dir(output int dx, output int dy);
		case ($urandom_range(9))
			0: begin dx = $urandom_range(1) ? 16384 : -16384; dy = 0; end
			1: begin dx = 0; dy = $urandom_range(1) ? 16384 : -16384; end
			2: begin dx = $signed(16'($urandom)); dy = $signed(16'($urandom)); end
			3: begin dx = $urandom_range(32) - 16; dy = $urandom_range(32768) - 16384; end
			default: begin
				dx = $urandom_range(32768) - 16384;
				dy = $urandom_range(32768) - 16384;
			end
		endcase
	endtask

	initial begin
		int dx, dy, cosv, w, h;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty map at reset settings, so every cast misses
		cast(16384, 0, 32768, 0);
		cast(0, 0, 32768, 1023);
		drain();
		// viewer in cell (2,2) of a walled ring
		write_reg(CFG_PLAYER_X, 2*512 + 100);
		write_reg(CFG_PLAYER_Y, 2*512 + 256);
		for (int i = 0; i < 5; i++) begin
			put_cell(i, 0, 1); put_cell(i, 4, 1); put_cell(0, i, 1); put_cell(4, i, 1);
		end
		cast(16384, 0, 32768, 2);
		cast(-16384, 0, 0, 3);
		cast(0, 16384, 65535, 4);
		cast(0, -16384, 32768, 5);
		cast(11585, 11585, 30000, 6);
		cast(-32768, -32768, 32768, 7);
		cast(0, 0, 32768, 8);
		cast(16384, 16384, 32768, 9);
		drain();
		// wall right next to the viewer: tiny distances, height and top saturation
		write_reg(CFG_PLAYER_X, 3*512 + 511);
		write_reg(CFG_PROJ_SCALE, 65535);
		write_reg(CFG_HORIZON, 0);
		cast(16384, 0, 32768, 10);
		cast(16384, 1, 1, 11);
		// zero map size misses, oversize acts as full size, dead indexes ignored
		drain();
		write_reg(CFG_MAP_WIDTH, 0);
		write_reg(6, 123);
		write_reg(7, 456);
		cast(16384, 0, 32768, 12);
		drain();
		write_reg(CFG_MAP_WIDTH, 63);
		write_reg(CFG_MAP_HEIGHT, 1);
		write_reg(CFG_PROJ_SCALE, 1);
		write_reg(CFG_HORIZON, 1023);
		cast(16384, 0, 32768, 13);
		cast(0, 16384, 32768, 14);
		drain();

		// random phases: new settings, then mostly casts mixed with map edits
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin w = 32; h = 32; end
				1: begin w = $urandom_range(8, 2); h = $urandom_range(8, 2); end
				2: begin w = $urandom_range(63, 33); h = 1; end
				default: begin w = $urandom_range(32, 1); h = $urandom_range(32, 1); end
			endcase
			write_reg(CFG_MAP_WIDTH, w);
			write_reg(CFG_MAP_HEIGHT, h);
			if (w > 32) w = 32;
			write_reg(CFG_PLAYER_X, (ph == 3) ? 16383 : (ph == 5) ? 0 : $urandom_range(w*512 - 1));
			write_reg(CFG_PLAYER_Y, (ph == 3) ? 16383 : (ph == 5) ? 0 : $urandom_range(h*512 - 1));
			write_reg(CFG_HORIZON, (ph == 1) ? 1023 : (ph == 6) ? 0 : $urandom_range(1023));
			write_reg(CFG_PROJ_SCALE, (ph == 2) ? 65535 : (ph == 7) ? 1 : $urandom_range(65535, 1));
			for (int n = 0; n < 56; n++) begin
				if ($urandom_range(99) < 30) begin
					// mostly walls inside the active area, now and then a clear
					put_cell($urandom_range(w - 1), $urandom_range((h > 32 ? 32 : h) - 1),
						$urandom_range(99) < 80);
				end else if ($urandom_range(99) < 5) begin
					put_cell($urandom_range(31), $urandom_range(31), $urandom_range(1));
				end else begin
					random_dir(dx, dy);
					cosv = ($urandom_range(9) == 0) ? $urandom_range(65535)
						: $urandom_range(32768, 20000);
					cast(dx, dy, cosv, $urandom_range(1023));
				end
			end
			drain();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== grid_ray_wall_caster.f =====
rtl/grc_pkg.sv
rtl/grc_if.sv
rtl/grc_div.sv
rtl/grid_ray_wall_caster.sv
tb/sv/tb.sv
